@@ design/rlpe_pkg.sv @@
// Package for the RLP item and list encoder: item kinds, header codes,
// widths and the per-item result burst type. No dependencies.
`timescale 1ns / 1ps

package rlpe_pkg;

    // Width of the item_length field and the number of its bits that count
    localparam int LEN_FIELD_W = 32;
    localparam int LENGTH_BITS = 32;
    localparam int LEN_BYTES   = LEN_FIELD_W / 8;
    // One header byte plus up to LEN_BYTES length bytes
    localparam int MAX_RESULTS = LEN_BYTES + 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int NB_W        = $clog2(LEN_BYTES + 1);

    // Header codes
    localparam logic [7:0] HDR_STR_SHORT  = 8'h80;
    localparam logic [7:0] HDR_STR_LONG   = 8'hb7;
    localparam logic [7:0] HDR_LIST_SHORT = 8'hc0;
    localparam logic [7:0] HDR_LIST_LONG  = 8'hf7;
    localparam logic [7:0] HDR_SINGLE_HI  = 8'h81;
    localparam int         SHORT_MAX      = 55;

    // Configuration register indexes
    localparam logic [0:0] REG_ZERO_AS_EMPTY = 1'b0;

    typedef enum logic [1:0] {
        KIND_STRING  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_LIST    = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    // Result bytes of one item, byte 0 goes out first
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
        logic                        err;
    } t_burst;

endpackage

@@ design/rlpe_cfg.sv @@
// APB configuration register for the RLP encoder (zero_as_empty).
// Depends on rlpe_pkg.
`timescale 1ns / 1ps

module rlpe_cfg import rlpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        o_zero_as_empty
);

    logic r_zero_as_empty;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == REG_ZERO_AS_EMPTY);

    // Register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_as_empty <= 1'b1;
        end else if (w_wr) begin
            r_zero_as_empty <= pwdata[0];
        end
    end

    // Read back, unmapped addresses read zero
    assign prdata = (paddr[2] == REG_ZERO_AS_EMPTY) ? {31'd0, r_zero_as_empty} : 32'd0;
    assign o_zero_as_empty = r_zero_as_empty;

endmodule

@@ design/rlpe_encode.sv @@
// Input register, encoder state and header/payload encoding of one item
// into a burst of up to MAX_RESULTS bytes. Depends on rlpe_pkg.
`timescale 1ns / 1ps

module rlpe_encode import rlpe_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_kind                  i_kind,
    input  logic [LEN_FIELD_W-1:0] i_item_length,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_zero_as_empty,
    input  logic                   i_buf_free,
    output logic                   o_load,
    output t_burst                 o_burst
);

    logic                   r_in_valid;
    t_kind                  r_kind;
    logic [LEN_FIELD_W-1:0] r_len;
    logic [7:0]             r_byte;
    logic [LEN_FIELD_W-1:0] r_remaining;
    logic                   r_single;
    logic [LEN_FIELD_W-1:0] n_remaining;
    logic                   n_single;

    logic [LEN_FIELD_W-1:0]          w_len;
    logic [LEN_BYTES-1:0][7:0]       w_len_bytes;
    logic [NB_W-1:0]                 w_nbytes;
    logic                            w_short;
    logic [MAX_RESULTS-1:0][7:0]     w_long;
    logic [NB_W-1:0]                 w_sh;
    t_burst                          w_burst;

    assign o_load  = r_in_valid && i_buf_free;
    assign o_ready = !r_in_valid || i_buf_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (o_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_kind <= i_kind;
            r_len  <= i_item_length;
            r_byte <= i_data_byte;
        end
    end

    // Keep only the low LENGTH_BITS bits of the length
    always_comb begin
        for (int i = 0; i < LEN_FIELD_W; i++) begin
            w_len[i] = r_len[i] && (i < LENGTH_BITS);
        end
    end

    assign w_len_bytes = w_len;
    assign w_short     = (w_len <= LEN_FIELD_W'(SHORT_MAX));

    // Number of significant length bytes
    always_comb begin
        w_nbytes = NB_W'(1);
        for (int i = 1; i < LEN_BYTES; i++) begin
            if (w_len_bytes[i] != 8'd0) begin
                w_nbytes = NB_W'(i + 1);
            end
        end
    end

    // Length bytes of a long header, most significant first after the header
    always_comb begin
        w_long = '0;
        w_sh   = '0;
        for (int k = 1; k <= LEN_BYTES; k++) begin
            w_sh = w_nbytes - NB_W'(k);
            if (NB_W'(k) <= w_nbytes) begin
                w_long[k] = w_len_bytes[w_sh[$clog2(LEN_BYTES)-1:0]];
            end
        end
    end

    // Encoding and next state
    always_comb begin
        w_burst     = '0;
        n_remaining = r_remaining;
        n_single    = r_single;
        case (r_kind)
            KIND_STRING: begin
                n_remaining = '0;
                n_single    = 1'b0;
                if (w_len == '0) begin
                    w_burst.bytes[0] = HDR_STR_SHORT;
                    w_burst.count    = CNT_W'(1);
                end else if (w_len == LEN_FIELD_W'(1)) begin
                    n_single = 1'b1;
                end else begin
                    n_remaining = w_len;
                    if (w_short) begin
                        w_burst.bytes[0] = HDR_STR_SHORT + w_len[7:0];
                        w_burst.count    = CNT_W'(1);
                    end else begin
                        w_burst.bytes    = w_long;
                        w_burst.bytes[0] = HDR_STR_LONG + 8'(w_nbytes);
                        w_burst.count    = CNT_W'(w_nbytes) + CNT_W'(1);
                    end
                end
            end
            KIND_LIST: begin
                n_remaining = '0;
                n_single    = 1'b0;
                if (w_short) begin
                    w_burst.bytes[0] = HDR_LIST_SHORT + w_len[7:0];
                    w_burst.count    = CNT_W'(1);
                end else begin
                    w_burst.bytes    = w_long;
                    w_burst.bytes[0] = HDR_LIST_LONG + 8'(w_nbytes);
                    w_burst.count    = CNT_W'(w_nbytes) + CNT_W'(1);
                end
            end
            KIND_PAYLOAD: begin
                if (r_single) begin
                    n_single = 1'b0;
                    if ((r_byte == 8'd0) && i_zero_as_empty) begin
                        w_burst.bytes[0] = HDR_STR_SHORT;
                        w_burst.count    = CNT_W'(1);
                    end else if (!r_byte[7]) begin
                        w_burst.bytes[0] = r_byte;
                        w_burst.count    = CNT_W'(1);
                    end else begin
                        w_burst.bytes[0] = HDR_SINGLE_HI;
                        w_burst.bytes[1] = r_byte;
                        w_burst.count    = CNT_W'(2);
                    end
                end else if (r_remaining != '0) begin
                    n_remaining      = r_remaining - LEN_FIELD_W'(1);
                    w_burst.bytes[0] = r_byte;
                    w_burst.count    = CNT_W'(1);
                end else begin
                    // stray payload byte: passed through and flagged
                    w_burst.bytes[0] = r_byte;
                    w_burst.count    = CNT_W'(1);
                    w_burst.err      = 1'b1;
                end
            end
            default: begin
                w_burst = '0;
            end
        endcase
    end

    // Encoder state, updated as the item moves into the output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_single    <= 1'b0;
        end else if (o_load) begin
            r_remaining <= n_remaining;
            r_single    <= n_single;
        end
    end

    assign o_burst = w_burst;

endmodule

@@ design/rlpe_out_buf.sv @@
// Output buffer for the RLP encoder: holds one item's result burst and shifts
// it out one byte per cycle while m_axis_tready is high. Depends on rlpe_pkg.
`timescale 1ns / 1ps

module rlpe_out_buf import rlpe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_burst     i_burst,
    output logic       o_buf_free,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // run_last
    output logic       m_axis_tuser    // [0] stray_error
);

    logic [MAX_RESULTS-1:0][7:0] r_bytes;
    logic [CNT_W-1:0]            r_rem;
    logic                        r_err;
    logic                        w_pop;

    assign w_pop      = m_axis_tvalid && m_axis_tready;
    assign o_buf_free = (r_rem == '0) || ((r_rem == CNT_W'(1)) && m_axis_tready);

    // Count of bytes still to send
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_load) begin
            r_rem <= i_burst.count;
        end else if (w_pop) begin
            r_rem <= r_rem - CNT_W'(1);
        end
    end

    // Byte shift register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
            r_err   <= i_burst.err;
        end else if (w_pop) begin
            r_bytes <= r_bytes >> 8;
        end
    end

    assign m_axis_tvalid = (r_rem != '0);
    assign m_axis_tdata  = r_bytes[0];
    assign m_axis_tlast  = (r_rem == CNT_W'(1));
    assign m_axis_tuser  = r_err;

endmodule

@@ design/rlp_item_and_list_encoder_unit.sv @@
// RLP item and list encoder, top level. An accepted item passes the input
// register, then the output buffer. Throughput: one item per cycle for items
// giving at most one byte, while m_axis_tready is high; an item giving k bytes
// holds the output buffer until all k are taken (k up to 5, long headers).
// Reset (synchronous, active low) empties both stages, clears the string
// state and sets zero_as_empty to 1. Depends on rlpe_pkg and submodules.
`timescale 1ns / 1ps

module rlp_item_and_list_encoder_unit import rlpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] item_length, [39:32] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser,   // [0] stray_error
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic   w_zero_as_empty;
    logic   w_buf_free;
    logic   w_load;
    t_burst w_burst;

    rlpe_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_zero_as_empty (w_zero_as_empty)
    );

    rlpe_encode u_encode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_kind          (t_kind'(s_axis_tuser)),
        .i_item_length   (s_axis_tdata[31:0]),
        .i_data_byte     (s_axis_tdata[39:32]),
        .i_zero_as_empty (w_zero_as_empty),
        .i_buf_free      (w_buf_free),
        .o_load          (w_load),
        .o_burst         (w_burst)
    );

    rlpe_out_buf u_out_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_burst       (w_burst),
        .o_buf_free    (w_buf_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // A stray-byte flag only rides on a single-byte result
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("stray error on a non-final byte");

    // Input stalls only while results are waiting at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output buffer");

    // A new burst never overwrites bytes not yet taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!m_axis_tvalid || (m_axis_tready && m_axis_tlast)))
        else $error("burst loaded over pending bytes");

endmodule
